[rtl/rbd_pkg.sv]
`timescale 1ns / 1ps
package rbd_pkg;
	localparam int CW = 16;
	localparam int VW = 18;
	localparam int MW = 17;
	localparam int SSW = 36;
	localparam int FRAC = 28;
	localparam int RADW = SSW + FRAC;
	localparam int RTW = RADW / 2;
	localparam int QW = 15;
	localparam int NW = 48;
	localparam int XSH = 14;
	localparam int UNIT = 16384;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int RW = 8;
	localparam logic REG_THR = 1'b0;
	localparam logic REG_NDG = 1'b1;
	localparam logic [RW-1:0] THR_RST = 8'd1;
	localparam logic [RW-1:0] NDG_RST = 8'd16;
endpackage

[rtl/rbd_if.sv]
`timescale 1ns / 1ps
interface rbd_in_if;
	logic valid;
	logic ready;
	logic signed [rbd_pkg::CW-1:0] dir_x;
	logic signed [rbd_pkg::CW-1:0] dir_y;
	logic signed [rbd_pkg::CW-1:0] dir_z;
	logic signed [rbd_pkg::CW-1:0] up_x;
	logic signed [rbd_pkg::CW-1:0] up_y;
	logic signed [rbd_pkg::CW-1:0] up_z;
	modport source (output valid, dir_x, dir_y, dir_z, up_x, up_y, up_z, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, up_x, up_y, up_z, output ready);
endinterface

interface rbd_out_if;
	logic valid;
	logic ready;
	logic signed [rbd_pkg::CW-1:0] right_x;
	logic signed [rbd_pkg::CW-1:0] right_y;
	logic signed [rbd_pkg::CW-1:0] right_z;
	logic signed [rbd_pkg::CW-1:0] upr_x;
	logic signed [rbd_pkg::CW-1:0] upr_y;
	logic signed [rbd_pkg::CW-1:0] upr_z;
	logic signed [rbd_pkg::CW-1:0] fwd_x;
	logic signed [rbd_pkg::CW-1:0] fwd_y;
	logic signed [rbd_pkg::CW-1:0] fwd_z;
	logic was_nudged;
	modport source (output valid, right_x, right_y, right_z, upr_x, upr_y, upr_z,
		fwd_x, fwd_y, fwd_z, was_nudged, input ready);
	modport sink (input valid, right_x, right_y, right_z, upr_x, upr_y, upr_z,
		fwd_x, fwd_y, fwd_z, was_nudged, output ready);
endinterface

[rtl/rotation_basis_from_direction_core.sv]
`timescale 1ns / 1ps
// One word per cycle while the result side does not stall; three normalizers
// of 51 stages each (32-stage square root, 15-stage divider) set the depth.
// A stall on the result side holds every stage at once.
// Reset clears all valid bits; parallel_threshold resets to 1, nudge_amount to 16.
module rotation_basis_from_direction_core (
	input  logic clk,
	input  logic arst_n,
	rbd_in_if.sink req,
	rbd_out_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rbd_pkg::CFG_AW-1:0] paddr,
	input  logic [rbd_pkg::CFG_DW-1:0] pwdata,
	output logic [rbd_pkg::CFG_DW-1:0] prdata,
	output logic pready
);
	import rbd_pkg::*;

	localparam int S2W = 3 * CW + 1;
	localparam int S3W = 6 * CW + 1;

	logic [RW-1:0] thr_q;
	logic [RW-1:0] ndg_q;
	logic en;

	assign pready = 1'b1;
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
			ndg_q <= NDG_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_THR: thr_q <= pwdata[RW-1:0];
				REG_NDG: ndg_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THR: prdata = CFG_DW'(thr_q);
			REG_NDG: prdata = CFG_DW'(ndg_q);
			default: prdata = '0;
		endcase
	end

	logic signed [VW-1:0] n1_in [2][3];
	logic n1_v;
	logic signed [CW-1:0] n1_out [2][3];
	logic [2*RW-1:0] n1_side;

	always_comb begin
		n1_in[0][0] = VW'(req.dir_x);
		n1_in[0][1] = VW'(req.dir_y);
		n1_in[0][2] = VW'(req.dir_z);
		n1_in[1][0] = VW'(req.up_x);
		n1_in[1][1] = VW'(req.up_y);
		n1_in[1][2] = VW'(req.up_z);
	end

	rbd_norm #(.NV(2), .SW(2 * RW)) u_norm_in (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(req.valid), .in_vec(n1_in), .in_side({thr_q, ndg_q}),
		.out_valid(n1_v), .out_vec(n1_out), .out_side(n1_side)
	);

	logic signed [CW:0] dd [3];
	logic [CW:0] ad [3];
	logic signed [CW:0] ds;
	logic [CW:0] as;
	logic [CW:0] thr_c;
	logic nud_c;

	always_comb begin
		thr_c = (CW+1)'(n1_side[2*RW-1:RW]);
		for (int k = 0; k < 3; k++) begin
			dd[k] = (CW+1)'(n1_out[0][k]) - (CW+1)'(n1_out[1][k]);
			ad[k] = dd[k][CW] ? (CW+1)'(-dd[k]) : (CW+1)'(dd[k]);
		end
		ds = (CW+1)'(n1_out[0][1]) + (CW+1)'(n1_out[1][1]);
		as = ds[CW] ? (CW+1)'(-ds) : (CW+1)'(ds);
		nud_c = ad[0] < thr_c && ad[2] < thr_c && (ad[1] < thr_c || as < thr_c);
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic nud_s1, nud_s2, nud_s3, nud_s4, nud_s5, nud_s6, nud_s7;
	logic signed [CW-1:0] f_s1 [3], f_s2 [3], f_s3 [3], f_s4 [3], f_s5 [3];
	logic signed [CW:0] w_s1 [3], w_s2 [3], w_s3 [3], w_s4 [3];
	logic signed [2*CW:0] pr_s2 [3];
	logic signed [2*CW+2:0] dot_s3;
	logic signed [3*CW+2:0] fd_s4 [3];
	logic signed [VW-1:0] p_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= n1_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic signed [3*CW+4:0] df [3];
	logic [3*CW+4:0] dm [3];
	logic [3*CW+4:0] dr [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			df[k] = ((3*CW+5)'(w_s4[k]) <<< FRAC) - (3*CW+5)'(fd_s4[k]);
			dm[k] = df[k][3*CW+4] ? (3*CW+5)'(-df[k]) : (3*CW+5)'(df[k]);
			dr[k] = (dm[k] + ((3*CW+5)'(1) << (FRAC - 1))) >> FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nud_s1 <= nud_c;
			nud_s2 <= nud_s1;
			nud_s3 <= nud_s2;
			nud_s4 <= nud_s3;
			nud_s5 <= nud_s4;
			dot_s3 <= (2*CW+3)'(pr_s2[0]) + (2*CW+3)'(pr_s2[1]) + (2*CW+3)'(pr_s2[2]);
			for (int k = 0; k < 3; k++) begin
				f_s1[k] <= n1_out[0][k];
				w_s1[k] <= (CW+1)'(n1_out[1][k]) + (nud_c ? (CW+1)'(n1_side[RW-1:0]) : '0);
				f_s2[k] <= f_s1[k];
				w_s2[k] <= w_s1[k];
				pr_s2[k] <= (2*CW+1)'(w_s1[k]) * (2*CW+1)'(f_s1[k]);
				f_s3[k] <= f_s2[k];
				w_s3[k] <= w_s2[k];
				f_s4[k] <= f_s3[k];
				w_s4[k] <= w_s3[k];
				fd_s4[k] <= (3*CW+3)'(f_s3[k]) * (3*CW+3)'(dot_s3);
				f_s5[k] <= f_s4[k];
				p_s5[k] <= df[k][3*CW+4] ? -VW'(dr[k][MW-1:0]) : VW'(dr[k][MW-1:0]);
			end
		end
	end

	logic signed [VW-1:0] n2_in [1][3];
	logic n2_v;
	logic signed [CW-1:0] n2_out [1][3];
	logic [S2W-1:0] n2_side;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n2_in[0][k] = p_s5[k];
		end
	end

	rbd_norm #(.NV(1), .SW(S2W)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .in_vec(n2_in), .in_side({f_s5[0], f_s5[1], f_s5[2], nud_s5}),
		.out_valid(n2_v), .out_vec(n2_out), .out_side(n2_side)
	);

	logic signed [CW-1:0] f2_c [3];
	logic signed [CW-1:0] r_s6 [3], r_s7 [3], f_s6 [3], f_s7 [3];
	logic signed [2*CW-1:0] xp_s6 [6];
	logic signed [VW-1:0] c_s7 [3];
	logic signed [2*CW:0] xd [3];
	logic [2*CW:0] xm [3];
	logic [2*CW:0] xr [3];

	always_comb begin
		f2_c[0] = n2_side[S2W-1:S2W-CW];
		f2_c[1] = n2_side[S2W-CW-1:S2W-2*CW];
		f2_c[2] = n2_side[CW:1];
		for (int k = 0; k < 3; k++) begin
			xd[k] = (2*CW+1)'(xp_s6[2*k]) - (2*CW+1)'(xp_s6[2*k+1]);
			xm[k] = xd[k][2*CW] ? (2*CW+1)'(-xd[k]) : (2*CW+1)'(xd[k]);
			xr[k] = (xm[k] + ((2*CW+1)'(1) << (XSH - 1))) >> XSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= n2_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nud_s6 <= n2_side[0];
			nud_s7 <= nud_s6;
			xp_s6[0] <= (2*CW)'(n2_out[0][1]) * (2*CW)'(f2_c[2]);
			xp_s6[1] <= (2*CW)'(n2_out[0][2]) * (2*CW)'(f2_c[1]);
			xp_s6[2] <= (2*CW)'(n2_out[0][2]) * (2*CW)'(f2_c[0]);
			xp_s6[3] <= (2*CW)'(n2_out[0][0]) * (2*CW)'(f2_c[2]);
			xp_s6[4] <= (2*CW)'(n2_out[0][0]) * (2*CW)'(f2_c[1]);
			xp_s6[5] <= (2*CW)'(n2_out[0][1]) * (2*CW)'(f2_c[0]);
			for (int k = 0; k < 3; k++) begin
				r_s6[k] <= n2_out[0][k];
				f_s6[k] <= f2_c[k];
				r_s7[k] <= r_s6[k];
				f_s7[k] <= f_s6[k];
				c_s7[k] <= xd[k][2*CW] ? -VW'(xr[k][MW-1:0]) : VW'(xr[k][MW-1:0]);
			end
		end
	end

	logic signed [VW-1:0] n3_in [1][3];
	logic signed [CW-1:0] n3_out [1][3];
	logic [S3W-1:0] n3_side;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n3_in[0][k] = c_s7[k];
		end
	end

	rbd_norm #(.NV(1), .SW(S3W)) u_norm_right (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s7), .in_vec(n3_in),
		.in_side({r_s7[0], r_s7[1], r_s7[2], f_s7[0], f_s7[1], f_s7[2], nud_s7}),
		.out_valid(rsp.valid), .out_vec(n3_out), .out_side(n3_side)
	);

	assign rsp.right_x = n3_out[0][0];
	assign rsp.right_y = n3_out[0][1];
	assign rsp.right_z = n3_out[0][2];
	assign rsp.upr_x = n3_side[6*CW:5*CW+1];
	assign rsp.upr_y = n3_side[5*CW:4*CW+1];
	assign rsp.upr_z = n3_side[4*CW:3*CW+1];
	assign rsp.fwd_x = n3_side[3*CW:2*CW+1];
	assign rsp.fwd_y = n3_side[2*CW:CW+1];
	assign rsp.fwd_z = n3_side[CW:1];
	assign rsp.was_nudged = n3_side[0];
endmodule

[rtl/rbd_norm.sv]
`timescale 1ns / 1ps
module rbd_norm #(
	parameter int NV = 1,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [rbd_pkg::VW-1:0] in_vec [NV][3],
	input  logic [SW-1:0] in_side,
	output logic out_valid,
	output logic signed [rbd_pkg::CW-1:0] out_vec [NV][3],
	output logic [SW-1:0] out_side
);
	import rbd_pkg::*;

	localparam int NS = RTW;
	localparam int ND = QW;

	logic [MW-1:0] mag_c [NV][3];
	logic [VW-1:0] neg_v [NV][3];

	logic v_s1;
	logic [SW-1:0] side_s1;
	logic [MW-1:0] mag_s1 [NV][3];
	logic neg_s1 [NV][3];
	logic [2*MW-1:0] sq_s1 [NV][3];

	logic rt_v_s [0:NS];
	logic [SW-1:0] rt_side_s [0:NS];
	logic [MW-1:0] rt_mag_s [0:NS][NV][3];
	logic rt_neg_s [0:NS][NV][3];
	logic rt_zero_s [0:NS][NV];
	logic [RADW-1:0] rt_rem_s [0:NS][NV];
	logic [RTW-1:0] rt_root_s [0:NS][NV];

	logic dv_v_s [0:ND];
	logic [SW-1:0] dv_side_s [0:ND];
	logic dv_neg_s [0:ND][NV][3];
	logic dv_zero_s [0:ND][NV];
	logic [RTW:0] dv_d_s [0:ND][NV];
	logic [NW-1:0] dv_rem_s [0:ND][NV][3];
	logic [QW-1:0] dv_q_s [0:ND][NV][3];

	logic [SSW-1:0] sum_c [NV];
	logic [QW-1:0] qs_c [NV][3];

	always_comb begin
		for (int n = 0; n < NV; n++) begin
			for (int k = 0; k < 3; k++) begin
				neg_v[n][k] = -in_vec[n][k];
				mag_c[n][k] = in_vec[n][k][VW-1] ? neg_v[n][k][MW-1:0] : in_vec[n][k][MW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			for (int n = 0; n < NV; n++) begin
				for (int k = 0; k < 3; k++) begin
					mag_s1[n][k] <= mag_c[n][k];
					neg_s1[n][k] <= in_vec[n][k][VW-1];
					sq_s1[n][k] <= (2*MW)'(mag_c[n][k]) * (2*MW)'(mag_c[n][k]);
				end
			end
		end
	end

	always_comb begin
		for (int n = 0; n < NV; n++) begin
			sum_c[n] = SSW'(sq_s1[n][0]) + SSW'(sq_s1[n][1]) + SSW'(sq_s1[n][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_side_s[0] <= side_s1;
			for (int n = 0; n < NV; n++) begin
				rt_zero_s[0][n] <= sum_c[n] == '0;
				rt_rem_s[0][n] <= {sum_c[n], {FRAC{1'b0}}};
				rt_root_s[0][n] <= '0;
				for (int k = 0; k < 3; k++) begin
					rt_mag_s[0][n][k] <= mag_s1[n][k];
					rt_neg_s[0][n][k] <= neg_s1[n][k];
				end
			end
		end
	end

	for (genvar j = 1; j <= NS; j++) begin : g_rt
		localparam int B = NS - j;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j] <= 1'b0;
			end else if (en) begin
				rt_v_s[j] <= rt_v_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_side_s[j] <= rt_side_s[j-1];
				rt_mag_s[j] <= rt_mag_s[j-1];
				rt_neg_s[j] <= rt_neg_s[j-1];
				rt_zero_s[j] <= rt_zero_s[j-1];
			end
		end
		for (genvar n = 0; n < NV; n++) begin : g_v
			logic [RADW+1:0] t;
			logic ge;
			assign t = ((RADW+2)'(rt_root_s[j-1][n]) << (B + 1)) | ((RADW+2)'(1) << (2 * B));
			assign ge = (RADW+2)'(rt_rem_s[j-1][n]) >= t;
			always_ff @(posedge clk) begin
				if (en) begin
					rt_rem_s[j][n] <= ge ? rt_rem_s[j-1][n] - t[RADW-1:0] : rt_rem_s[j-1][n];
					rt_root_s[j][n] <= ge ? (rt_root_s[j-1][n] | (RTW'(1) << B))
						: rt_root_s[j-1][n];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= rt_side_s[NS];
			dv_neg_s[0] <= rt_neg_s[NS];
			dv_zero_s[0] <= rt_zero_s[NS];
			for (int n = 0; n < NV; n++) begin
				dv_d_s[0][n] <= {rt_root_s[NS][n], 1'b0};
				for (int k = 0; k < 3; k++) begin
					dv_rem_s[0][n][k] <= (NW'(rt_mag_s[NS][n][k]) << (FRAC + 1))
						+ NW'(rt_root_s[NS][n]);
					dv_q_s[0][n][k] <= '0;
				end
			end
		end
	end

	for (genvar j = 1; j <= ND; j++) begin : g_dv
		localparam int K = ND - j;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[j] <= dv_side_s[j-1];
				dv_neg_s[j] <= dv_neg_s[j-1];
				dv_zero_s[j] <= dv_zero_s[j-1];
				dv_d_s[j] <= dv_d_s[j-1];
			end
		end
		for (genvar n = 0; n < NV; n++) begin : g_v
			for (genvar k = 0; k < 3; k++) begin : g_k
				logic [NW-1:0] t;
				logic ge;
				assign t = NW'(dv_d_s[j-1][n]) << K;
				assign ge = dv_rem_s[j-1][n][k] >= t;
				always_ff @(posedge clk) begin
					if (en) begin
						dv_rem_s[j][n][k] <= ge ? dv_rem_s[j-1][n][k] - t : dv_rem_s[j-1][n][k];
						dv_q_s[j][n][k] <= ge ? (dv_q_s[j-1][n][k] | (QW'(1) << K))
							: dv_q_s[j-1][n][k];
					end
				end
			end
		end
	end

	always_comb begin
		for (int n = 0; n < NV; n++) begin
			for (int k = 0; k < 3; k++) begin
				qs_c[n][k] = (dv_q_s[ND][n][k] > QW'(UNIT)) ? QW'(UNIT) : dv_q_s[ND][n][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= dv_side_s[ND];
			for (int n = 0; n < NV; n++) begin
				for (int k = 0; k < 3; k++) begin
					if (dv_zero_s[ND][n]) begin
						out_vec[n][k] <= '0;
					end else if (dv_neg_s[ND][n][k]) begin
						out_vec[n][k] <= -CW'(qs_c[n][k]);
					end else begin
						out_vec[n][k] <= CW'(qs_c[n][k]);
					end
				end
			end
		end
	end
endmodule
